// ===== rtl/sm3_hash_engine_assert.svh =====
// Assertion macros for the SM3 hash engine checker.
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH
// Implication checked on every clock, skipped while in reset.
`define SM3_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: check failed");
// Implication checked in the next cycle.
`define SM3_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");
`endif

// ===== rtl/sm3_pkg.sv =====
// Package for the SM3 hash engine: types, constants and round functions.
`timescale 1ns / 1ps
package sm3_pkg;
   localparam int WordWidth  = 32;
   localparam int TotalWidth = 61;
   localparam logic [31:0] TLow  = 32'h79cc4519;
   localparam logic [31:0] THigh = 32'h7a879d8a;
   localparam logic [7:0]  PadByte = 8'h80;
   localparam logic [255:0] InitValue = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   typedef enum logic [2:0] {
      ST_IDLE, ST_ABSORB, ST_PAD, ST_LEN, ST_ROUND, ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_word;   // merge input word into block
      logic pad_fill;    // write 0x80 and zero the tail
      logic clear_block; // zero the whole block
      logic put_len;     // write bit length into words 14..15
      logic load_work;   // A..H <= V, start expansion
      logic do_round;    // one round
      logic fold;        // V ^= A..H
      logic restart;     // V <= IV, total <= 0
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic block_full;  // byte position wrapped to 0 on last take
      logic pad_two;     // pad position >= 56
      logic last_round;  // round 63 in progress
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [5:0] n);
      logic [63:0] d;
      d = {v, v} << n[4:0];
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] v);
      return v ^ rotl(v, 6'd9) ^ rotl(v, 6'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] v);
      return v ^ rotl(v, 6'd15) ^ rotl(v, 6'd23);
   endfunction
endpackage

// ===== rtl/sm3_ctrl.sv =====
// SM3 controller state machine.
`timescale 1ns / 1ps
module sm3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               req_end,
   input  logic               rsp_fire,
   input  sm3_pkg::status_type status,
   output sm3_pkg::cmd_type    cmd,
   output logic               req_ready,
   output logic               emit_valid,
   output logic [2:0]         emit_index
);
   import sm3_pkg::*;

   state_type state_ff, state_in;
   logic      final_ff, final_in;   // compression belongs to message end
   logic      second_ff, second_in; // a length block still follows
   logic [2:0] idx_ff, idx_in;
   // Final item filled a block exactly: padding comes after that compression.
   logic      pad_pending_ff, pad_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         second_ff <= second_in;
         idx_ff    <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      second_in = second_ff;
      idx_in    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               final_in = req_end;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            // data merged; compress if block full, else pad if final
            if (status.block_full) begin
               state_in = ST_ROUND;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            second_in = status.pad_two;
            state_in  = status.pad_two ? ST_ROUND : ST_LEN;
         end
         ST_LEN: begin
            second_in = 1'b0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.last_round) begin
               if (!final_ff) begin
                  state_in = ST_IDLE;
               end else if (second_ff) begin
                  state_in = ST_LEN;
               end else begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // block just filled by the final item: pad after its compression
      if (state_ff == ST_ROUND && status.last_round && final_ff && !second_ff
          && pad_pending_ff) begin
         state_in = ST_PAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_pending_ff <= 1'b0;
      end else begin
         pad_pending_ff <= pad_pending_in;
      end
   end
   always_comb begin
      pad_pending_in = pad_pending_ff;
      if (state_ff == ST_ABSORB) begin
         pad_pending_in = status.block_full && final_ff;
      end else if (state_ff == ST_PAD) begin
         pad_pending_in = 1'b0;
      end
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      emit_valid  = 1'b0;
      emit_index  = idx_ff;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_ABSORB: begin
            cmd.take_word = 1'b1;
            cmd.load_work = status.block_full;
         end
         ST_PAD: begin
            cmd.pad_fill  = 1'b1;
            cmd.load_work = status.pad_two;
         end
         ST_LEN: begin
            cmd.put_len     = 1'b1;
            cmd.clear_block = second_ff;
            cmd.load_work   = 1'b1;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            cmd.fold     = status.last_round;
         end
         ST_EMIT: begin
            emit_valid  = 1'b1;
            cmd.restart = rsp_fire && (idx_ff == 3'd7);
         end
         default: cmd = '0;
      endcase
   end
endmodule

// ===== rtl/sm3_datapath.sv =====
// SM3 datapath: block buffer, message expansion window, round logic, chain value.
`timescale 1ns / 1ps
module sm3_datapath #(
   parameter int TOTAL_W = sm3_pkg::TotalWidth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [31:0]        req_word,
   input  logic [2:0]         req_count,
   input  logic               req_end,
   input  sm3_pkg::cmd_type    cmd,
   input  logic [2:0]         emit_index,
   output sm3_pkg::status_type status,
   output logic [31:0]        digest_word
);
   import sm3_pkg::*;

   logic [31:0] blk_ff [16];
   logic [31:0] win_ff [16];        // expansion window, w[r..r+15]
   logic [255:0] v_ff, v_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [5:0]  round_ff;
   logic [31:0] tj_ff;              // rotl(T, r), rotated a step each round
   logic [31:0] hold_word_ff;
   logic [2:0]  hold_cnt_ff;
   logic [5:0]  pos;

   assign pos = total_ff[5:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_word_ff <= req_word;
         hold_cnt_ff  <= (!req_end || req_count > 3'd4) ? 3'd4 : req_count;
      end
   end

   // word merge: bytes land at pos .. pos+cnt-1 (never crosses block end
   // since pos is a multiple of 4 until the final short item)
   logic [2:0]  cnt;
   logic [6:0]  pos_after;
   assign cnt       = hold_cnt_ff;
   assign pos_after = {1'b0, pos} + {4'd0, cnt};

   always_comb begin
      total_in = total_ff;
      if (cmd.restart) begin
         total_in = '0;
      end else if (cmd.take_word) begin
         total_in = total_ff + TOTAL_W'(cnt);
      end
   end

   assign status.block_full = cmd.take_word ? pos_after[6] : 1'b0;
   assign status.pad_two    = (pos >= 6'd56);
   assign status.last_round = (round_ff == 6'd63);

   logic [63:0] bitlen;
   assign bitlen = {total_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (cmd.take_word) begin
         for (int k = 0; k < 4; k++) begin
            if (k < 32'(cnt)) begin
               blk_ff[pos[5:2]][31-8*k -: 8] <= hold_word_ff[31-8*k -: 8];
            end
         end
      end else if (cmd.pad_fill) begin
         for (int i = 0; i < 16; i++) begin
            for (int k = 0; k < 4; k++) begin
               if (i * 4 + k == 32'(pos)) begin
                  blk_ff[i][31-8*k -: 8] <= PadByte;
               end else if (i * 4 + k > 32'(pos)) begin
                  blk_ff[i][31-8*k -: 8] <= 8'h00;
               end
            end
         end
      end else if (cmd.put_len) begin
         if (cmd.clear_block) begin
            for (int i = 0; i < 14; i++) blk_ff[i] <= '0;
         end
         blk_ff[14] <= bitlen[63:32];
         blk_ff[15] <= bitlen[31:0];
      end
   end

   // length block must see cleared words when it follows a second pad
   logic [31:0] load_src [16];
   always_comb begin
      for (int i = 0; i < 16; i++) load_src[i] = blk_ff[i];
      if (cmd.take_word) begin
         for (int k = 0; k < 4; k++) begin
            if (k < 32'(cnt)) load_src[pos[5:2]][31-8*k -: 8] = hold_word_ff[31-8*k -: 8];
         end
      end else if (cmd.pad_fill) begin
         for (int i = 0; i < 16; i++) begin
            for (int k = 0; k < 4; k++) begin
               if (i * 4 + k == 32'(pos)) load_src[i][31-8*k -: 8] = PadByte;
               else if (i * 4 + k > 32'(pos)) load_src[i][31-8*k -: 8] = 8'h00;
            end
         end
      end else if (cmd.put_len) begin
         if (cmd.clear_block) begin
            for (int i = 0; i < 14; i++) load_src[i] = '0;
         end
         load_src[14] = bitlen[63:32];
         load_src[15] = bitlen[31:0];
      end
   end

   logic [31:0] w_new, w0, w4;
   assign w0    = win_ff[0];
   assign w4    = win_ff[4];
   assign w_new = p1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 6'd15))
                  ^ rotl(win_ff[3], 6'd7) ^ win_ff[10];

   logic        early;
   logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
   assign early = (round_ff < 6'd16);
   assign a12 = rotl(a_ff, 6'd12);
   assign ss1 = rotl(a12 + e_ff + tj_ff, 6'd7);
   assign ss2 = ss1 ^ a12;
   assign ff  = early ? (a_ff ^ b_ff ^ c_ff)
                      : ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
   assign gg  = early ? (e_ff ^ f_ff ^ g_ff) : ((e_ff & f_ff) ^ (~e_ff & g_ff));
   assign tt1 = ff + d_ff + ss2 + (w0 ^ w4);
   assign tt2 = gg + h_ff + ss1 + w0;

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         for (int i = 0; i < 16; i++) win_ff[i] <= load_src[i];
         {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff} <= v_ff;
         round_ff <= '0;
         tj_ff    <= TLow;
      end else if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= w_new;
         d_ff <= c_ff; c_ff <= rotl(b_ff, 6'd9); b_ff <= a_ff; a_ff <= tt1;
         h_ff <= g_ff; g_ff <= rotl(f_ff, 6'd19); f_ff <= e_ff; e_ff <= p0(tt2);
         round_ff <= round_ff + 6'd1;
         // next round's rotated constant; round 16 switches to rotl(THigh, 16)
         tj_ff <= (round_ff == 6'd15) ? rotl(THigh, 6'd16) : rotl(tj_ff, 6'd1);
      end
   end

   always_comb begin
      v_in = v_ff;
      if (cmd.restart) begin
         v_in = InitValue;
      end else if (cmd.fold) begin
         v_in = v_ff ^ {tt1, a_ff, rotl(b_ff, 6'd9), c_ff,
                        p0(tt2), e_ff, rotl(f_ff, 6'd19), g_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= InitValue;
         total_ff <= '0;
      end else begin
         v_ff     <= v_in;
         total_ff <= total_in;
      end
   end

   assign digest_word = v_ff[255 - 32*emit_index -: 32];
endmodule

// ===== rtl/sm3_hash_engine.sv =====
// SM3 hash engine top level.
// Usage:
//  req_ channel: one 32-bit message word per item, big-endian, with a byte
//  count in tuser and the last-of-message mark in tlast.
//  rsp_ channel: after the last item, eight digest words, word 0 first,
//  index in tuser, tlast on word 7.
// Each word passes through the idle and absorb states; the word that fills
//  a 64-byte block also runs the 64 compression rounds in the single round
//  unit before new items are taken.
// After the last item the engine pads and appends the bit length, compressing
//  one more block, or two when padding spills over or the last item fills a
//  block, then gives one digest word per cycle while rsp_tready is high.
// One item is in work at a time; req_tready is low while it is.
// Reset clears the chaining value to the SM3 initial value and the length.
// A stall on rsp_ holds the current digest word and blocks new items.
`timescale 1ns / 1ps
module sm3_hash_engine #(
   parameter int TOTAL_W = sm3_pkg::TotalWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] data_word
   input  logic [2:0]  req_tuser,  // [2:0] bytes_valid
   input  logic        req_tlast,  // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] digest_word
   output logic [2:0]  rsp_tuser,  // [2:0] word_index
   output logic        rsp_tlast   // digest_last
);
   import sm3_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   sm3_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_end(req_tlast), .rsp_fire,
      .status, .cmd, .req_ready(req_tready), .emit_valid(rsp_tvalid),
      .emit_index(rsp_tuser)
   );

   sm3_datapath #(.TOTAL_W(TOTAL_W)) u_dp (
      .clock, .reset, .req_fire, .req_word(req_tdata), .req_count(req_tuser),
      .req_end(req_tlast), .cmd, .emit_index(rsp_tuser), .status,
      .digest_word(rsp_tdata)
   );

   assign rsp_tlast = (rsp_tuser == 3'd7);
endmodule

// ===== rtl/sm3_hash_engine_checker.sv =====
// Port-level checker for the SM3 hash engine, bound to the top level.
`timescale 1ns / 1ps
`include "sm3_hash_engine_assert.svh"
module sm3_hash_engine_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `SM3_ASSERT_IMP(no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `SM3_ASSERT_IMP(last_on_seven, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == 3'd7))
   `SM3_ASSERT_NEXT(index_steps, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1)
   `SM3_ASSERT_NEXT(hold_stalled, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule

bind sm3_hash_engine sm3_hash_engine_checker u_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .rsp_tlast
);

// ===== verif/sm3_hash_checker.sv =====
// Checker for the SM3 hash engine: predicts digests from accepted items and compares results.
`timescale 1ns / 1ps
module sm3_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          digests_pending
);
   import sm3_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   logic [31:0] chain [8];
   logic [31:0] blk [16];
   logic [60:0] msg_bytes;
   digest_item_type digest_q [$];

   function automatic logic [31:0] rol(logic [31:0] v, int n);
      n = n % 32;
      return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
   endfunction

   function automatic logic [31:0] perm_p0(logic [31:0] v);
      return v ^ rol(v, 9) ^ rol(v, 17);
   endfunction

   function automatic logic [31:0] perm_p1(logic [31:0] v);
      return v ^ rol(v, 15) ^ rol(v, 23);
   endfunction

   task automatic compress();
      logic [31:0] w [68];
      logic [31:0] x [8];
      logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tc;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++)
         w[j] = perm_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 8; j++) x[j] = chain[j];
      for (int r = 0; r < 64; r++) begin
         tc = (r < 16) ? TLow : THigh;
         a12 = rol(x[0], 12);
         ss1 = rol(a12 + x[4] + rol(tc, r), 7);
         ss2 = ss1 ^ a12;
         if (r < 16) begin
            ff = x[0] ^ x[1] ^ x[2];
            gg = x[4] ^ x[5] ^ x[6];
         end else begin
            ff = (x[0] & x[1]) ^ (x[0] & x[2]) ^ (x[1] & x[2]);
            gg = (x[4] & x[5]) ^ (~x[4] & x[6]);
         end
         tt1 = ff + x[3] + ss2 + (w[r] ^ w[r+4]);
         tt2 = gg + x[7] + ss1 + w[r];
         x[3] = x[2]; x[2] = rol(x[1], 9); x[1] = x[0]; x[0] = tt1;
         x[7] = x[6]; x[6] = rol(x[5], 19); x[5] = x[4]; x[4] = perm_p0(tt2);
      end
      for (int j = 0; j < 8; j++) chain[j] ^= x[j];
   endtask

   task automatic put_byte(int pos, logic [7:0] b);
      int sh;
      sh = (3 - pos % 4) * 8;
      blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(b) << sh);
   endtask

   task automatic restart_message();
      for (int j = 0; j < 8; j++) chain[j] = InitValue[255 - 32*j -: 32];
      msg_bytes = '0;
   endtask

   task automatic absorb_item(logic [31:0] data, logic [2:0] cnt, logic fin);
      int n, len;
      logic [63:0] bits;
      n = (!fin || cnt > 4) ? 4 : cnt;
      for (int i = 0; i < n; i++) begin
         len = int'(msg_bytes[5:0]);
         put_byte(len, data[31 - 8*i -: 8]);
         msg_bytes = msg_bytes + 1;
         if (len == 63) compress();
      end
      if (!fin) return;
      len = int'(msg_bytes[5:0]);
      for (int i = len; i < 64; i++) put_byte(i, 8'h00);
      put_byte(len, PadByte);
      if (len >= 56) begin
         compress();
         for (int j = 0; j < 16; j++) blk[j] = '0;
      end
      bits = {msg_bytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
      restart_message();
   endtask

   always @(posedge clock) begin
      digest_item_type exp_item;
      if (reset) begin
         restart_message();
         digest_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected digest item: word %h index %0d", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               exp_item = digest_q.pop_front();
               if (rsp_tdata !== exp_item.word) begin
                  $error("digest_word expected %h actual %h", exp_item.word, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== exp_item.index) begin
                  $error("word_index expected %0d actual %0d", exp_item.index, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== exp_item.last) begin
                  $error("digest_last expected %0d actual %0d", exp_item.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) absorb_item(req_tdata, req_tuser, req_tlast);
      end
      digests_pending = digest_q.size();
   end
endmodule

// ===== verif/testbench.sv =====
// Testbench top: drives messages into the SM3 hash engine and gives the verdict.
`timescale 1ns / 1ps
module testbench;
   localparam int StallLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          digests_pending;
   int          idle_cycles = 0;
   int          items_sent = 0;
   int          rsp_gap = 0;

   always #5 clock = ~clock;

   sm3_hash_engine u_top (.*);

   sm3_hash_checker u_checker (.*);

   // mostly short gaps, occasionally long ones, sometimes none for a while
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // receiver: ready for one cycle, then a random gap
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap    <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // tvalid stays high into the next item when there is no gap
   task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic fin);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cnt;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // body words with random (often odd) counts, then an ending word
   task automatic send_message(int words, logic [2:0] end_cnt);
      for (int i = 0; i < words; i++) send_word($urandom, 3'($urandom), 1'b0);
      send_word($urandom, end_cnt, 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (digests_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty message, then "abc"
      send_word(32'h0, 3'd0, 1'b1);
      send_word(32'h61626300, 3'd3, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      send_word(32'h00000000, 3'd7, 1'b1);
      send_word(32'h12345678, 3'd1, 1'b1);
      send_word(32'h87654321, 3'd2, 1'b1);
      send_word(32'hffffffff, 3'd5, 1'b1);
      send_word(32'h0, 3'd6, 1'b1);
      // short count on a non-final item is taken as four
      send_word(32'haaaaaaaa, 3'd1, 1'b0);
      send_word(32'h55555555, 3'd0, 1'b1);
      // pad lengths around the one/two block boundary and full blocks
      send_message(13, 3'd3);
      send_message(13, 3'd4);
      send_message(14, 3'd0);
      send_message(15, 3'd4);
      drain();
      while (items_sent < 350) begin
         case ($urandom_range(0, 3))
            0: send_message($urandom_range(0, 3), 3'($urandom));
            1: send_message($urandom_range(12, 17), 3'($urandom));
            2: send_message($urandom_range(0, 40), 3'($urandom));
            default: send_message($urandom_range(28, 33), 3'($urandom));
         endcase
      end
      drain();
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
